@@ rtl/pls_pkg.sv @@
// package for the positional list store
// payload structs, operation and status codes, sizing constants; no dependencies
`timescale 1ns / 1ps
package pls_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int CMP_W     = 9;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_GET    = 2'd2
  } action_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
  } out_item_t;

endpackage

@@ rtl/pls_cells.sv @@
// entry array and length counter of the positional list store
// each entry shifts from a neighbor in parallel; uses pls_pkg
`timescale 1ns / 1ps
module pls_cells #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_en,
  input  pls_pkg::in_item_t op,
  output pls_pkg::out_item_t res
);

  localparam int LENW = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);

  logic [pls_pkg::DATA_W-1:0] ent_r   [DEPTH];
  logic [pls_pkg::DATA_W-1:0] ent_nxt [DEPTH];
  logic [LENW-1:0]            len_r;
  logic [LENW-1:0]            len_nxt;

  logic [pls_pkg::CMP_W-1:0] len_c;
  logic [pls_pkg::CMP_W-1:0] pos_c;
  logic [pls_pkg::CMP_W-1:0] ins_c;
  logic                      full;
  logic                      beyond;
  logic                      do_ins;
  logic                      do_era;

  assign len_c  = pls_pkg::CMP_W'(len_r);
  assign pos_c  = pls_pkg::CMP_W'(op.position);
  assign ins_c  = (pos_c > len_c) ? len_c : pos_c;
  assign full   = (len_r == LENW'(DEPTH));
  assign beyond = (pos_c >= len_c);
  assign do_ins = (op.action == pls_pkg::ACT_INSERT) && !full;
  assign do_era = (op.action == pls_pkg::ACT_ERASE) && !beyond;

  for (genvar i = 0; i < DEPTH; i++) begin : g_ent
    logic [pls_pkg::CMP_W-1:0] idx;
    logic [pls_pkg::DATA_W-1:0] lower;
    logic [pls_pkg::DATA_W-1:0] upper;
    assign idx = pls_pkg::CMP_W'(i);
    if (i > 0) begin : g_lo
      assign lower = ent_r[i-1];
    end else begin : g_lo0
      assign lower = '0;
    end
    if (i < DEPTH - 1) begin : g_up
      assign upper = ent_r[i+1];
    end else begin : g_up0
      assign upper = '0;
    end
    always_comb begin
      ent_nxt[i] = ent_r[i];
      if (do_ins) begin
        if (idx > ins_c) begin
          ent_nxt[i] = lower;
        end else if (idx == ins_c) begin
          ent_nxt[i] = op.item_value;
        end
      end else if (do_era) begin
        if (idx >= pos_c) begin
          ent_nxt[i] = upper;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ent_r[i] <= '0;
      end else if (op_en) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (do_ins) begin
      len_nxt = len_r + LENW'(1);
    end else if (do_era) begin
      len_nxt = len_r - LENW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (op_en) begin
      len_r <= len_nxt;
    end
  end

  always_comb begin
    res.read_value = '0;
    res.status     = pls_pkg::ST_DONE;
    case (op.action)
      pls_pkg::ACT_INSERT: begin
        if (full) begin
          res.status = pls_pkg::ST_FULL;
        end
      end
      pls_pkg::ACT_ERASE: begin
        if (beyond) begin
          res.status = pls_pkg::ST_BEYOND;
        end
      end
      pls_pkg::ACT_GET: begin
        if (beyond) begin
          res.status = pls_pkg::ST_BEYOND;
        end else begin
          res.read_value = ent_r[op.position[IW-1:0]];
        end
      end
      default: begin
        res.status = pls_pkg::ST_DONE;
      end
    endcase
  end

endmodule

@@ rtl/positional_list_store.sv @@
// top level of the positional list store
// input register, pls_cells entry array, result register; uses pls_pkg
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit values. Each transfer is insert,
// erase or get and yields exactly one result transfer. An accepted item sits
// in the input register, is executed against the entry array and lands in
// the result register, so one item per cycle is sustained while out_stall
// does not hold the result register. All entries shift in parallel, so an
// insert or erase costs no more than a get. Reset clears the list at once;
// no clearing pass is needed.
module positional_list_store #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pls_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pls_pkg::out_item_t out_data
);

  logic               s1_valid_r;
  pls_pkg::in_item_t  s1_data_r;
  logic               out_valid_r;
  pls_pkg::out_item_t out_data_r;
  pls_pkg::out_item_t res;
  logic               advance;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  pls_cells #(
    .DEPTH(DEPTH)
  ) u_cells (
    .clk   (clk),
    .rst_n (rst_n),
    .op_en (advance),
    .op    (s1_data_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
